FILE: rtl/infix_expression_evaluator_unit_defines.svh
// Assertion macros used by the port-level checker file.
// No dependencies.
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// Property that must hold in the cycle after the antecedent.
`define IEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Property that must hold in the same cycle as the antecedent.
`define IEE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/iee_pkg.sv
// Package for the infix expression evaluator: types, codes and reset values.
// No dependencies.
package iee_pkg;

    localparam int unsigned DefStackDepth = 32;

    localparam logic [63:0] ResetOperandA = 64'd10080;
    localparam logic [63:0] ResetOperandB = 64'd1100;
    localparam logic [63:0] ResetOperandC = 64'd11180;
    localparam logic [63:0] ResetOperandD = 64'd12280;

    typedef enum logic [2:0] {
        OP_PAREN = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_OTHER = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_A = 2'd0,
        REG_B = 2'd1,
        REG_C = 2'd2,
        REG_D = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,     // waiting for a byte
        S_DECIDE,   // operator stack top read data valid
        S_POP1,     // right operand read data valid
        S_POP2,     // left operand read data valid
        S_MUL,      // iterative multiply
        S_DIV,      // iterative divide
        S_WB,       // push result
        S_FINTOP,   // operator stack top read issued for the final reduction
        S_FINAL,    // final count check
        S_FINRD,    // final value read data valid
        S_OUT       // result held for output
    } state_t;

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChLpar  = 8'h28;
    localparam logic [7:0] ChRpar  = 8'h29;
    localparam logic [7:0] ChMul   = 8'h2A;
    localparam logic [7:0] ChAdd   = 8'h2B;
    localparam logic [7:0] ChSub   = 8'h2D;
    localparam logic [7:0] ChDiv   = 8'h2F;
    localparam logic [7:0] ChA     = 8'h41;
    localparam logic [7:0] ChB     = 8'h42;
    localparam logic [7:0] ChC     = 8'h43;
    localparam logic [7:0] ChD     = 8'h44;

    function automatic logic [1:0] prec(input logic [2:0] op);
        logic [1:0] p;
        p = 2'd0;
        if (op == OP_ADD || op == OP_SUB) p = 2'd1;
        if (op == OP_MUL || op == OP_DIV) p = 2'd2;
        return p;
    endfunction

endpackage

FILE: rtl/infix_expression_evaluator_unit.sv
// Top level of the infix expression evaluator: control, both stacks, arithmetic.
// Depends on iee_pkg.
//
// Takes one ASCII byte per transaction and evaluates the infix expression with
// a value stack and an operator stack, each a synchronous RAM of STACK_DEPTH
// entries with a registered read. A letter, a space or '(' is handled in S_IDLE;
// an operator or ')' also visits S_DECIDE to read the operator stack top, and
// every reduction runs S_POP1, S_POP2 and S_WB, plus S_MUL for a multiply (one
// bit per cycle, shift and add) or S_DIV for a divide (restoring, one quotient
// bit per cycle). The byte marked last then drains the operator stack (same
// steps per reduction) and runs S_FINTOP, S_FINAL and S_FINRD before value and
// status appear; the result sits in an output register until taken, and the
// next byte is accepted once it has gone. One byte is in work at a time.
module infix_expression_evaluator_unit
    import iee_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = DefStackDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] token
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] value, [65:64] status, zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] Full = CW'(STACK_DEPTH);

    logic [63:0] opnd_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opnd_reg[REG_A] <= ResetOperandA;
            opnd_reg[REG_B] <= ResetOperandB;
            opnd_reg[REG_C] <= ResetOperandC;
            opnd_reg[REG_D] <= ResetOperandD;
        end else if (cfg_we) begin
            opnd_reg[cfg_index] <= cfg_wdata;
        end
    end

    // stacks
    logic [63:0] vmem [STACK_DEPTH];
    logic [2:0]  omem [STACK_DEPTH];
    logic          v_we, o_we;
    logic [AW-1:0] v_waddr, v_raddr, o_waddr, o_raddr;
    logic [63:0]   v_wdata, v_rdata;
    logic [2:0]    o_wdata, o_rdata;

    always_ff @(posedge aclk) begin
        if (v_we) vmem[v_waddr] <= v_wdata;
        v_rdata <= vmem[v_raddr];
    end

    always_ff @(posedge aclk) begin
        if (o_we) omem[o_waddr] <= o_wdata;
        o_rdata <= omem[o_raddr];
    end

    state_t state_reg, state_next;
    logic [CW-1:0] vcnt_reg, vcnt_next, ocnt_reg, ocnt_next;
    logic [1:0]    err_reg, err_next;
    logic          last_reg, last_next;
    logic [2:0]    tok_reg, tok_next;     // operator code of the pending byte
    logic          rpar_reg, rpar_next;   // pending byte is ')'
    logic [2:0]    op_reg, op_next;
    logic [63:0]   r_reg, r_next, l_reg, l_next;
    logic [63:0]   acc_reg, acc_next;
    logic [63:0]   rem_reg, rem_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [63:0]   outv_reg, outv_next;
    logic [1:0]    outs_reg, outs_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            vcnt_reg  <= '0;
            ocnt_reg  <= '0;
            err_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            vcnt_reg  <= vcnt_next;
            ocnt_reg  <= ocnt_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
        tok_reg  <= tok_next;
        rpar_reg <= rpar_next;
        op_reg   <= op_next;
        r_reg    <= r_next;
        l_reg    <= l_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        outv_reg <= outv_next;
        outs_reg <= outs_next;
    end

    logic [64:0] trial;
    logic [63:0] pres;

    always_comb begin
        state_next = state_reg;
        vcnt_next = vcnt_reg;
        ocnt_next = ocnt_reg;
        err_next  = err_reg;
        last_next = last_reg;
        tok_next  = tok_reg;
        rpar_next = rpar_reg;
        op_next   = op_reg;
        r_next    = r_reg;
        l_next    = l_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        outv_next = outv_reg;
        outs_next = outs_reg;
        v_we = 1'b0;
        o_we = 1'b0;
        v_waddr = vcnt_reg[AW-1:0];
        o_waddr = ocnt_reg[AW-1:0];
        v_wdata = acc_reg;
        o_wdata = tok_reg;
        v_raddr = AW'(vcnt_reg - CW'(1));
        o_raddr = AW'(ocnt_reg - CW'(1));
        s_tready = 1'b0;
        trial = {rem_reg, acc_reg[63]} - {1'b0, r_reg};
        pres = '0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    last_next = s_tlast;
                    rpar_next = 1'b0;
                    state_next = s_tlast ? S_FINTOP : S_IDLE;
                    if (err_reg == ST_OK) begin
                        priority case (s_tdata)
                            ChSpace: ;
                            ChA, ChB, ChC, ChD: begin
                                if (vcnt_reg >= Full) err_next = ST_OVERFLOW;
                                else begin
                                    v_we = 1'b1;
                                    v_wdata = opnd_reg[s_tdata[1:0] - 2'd1];
                                    vcnt_next = vcnt_reg + CW'(1);
                                end
                            end
                            ChLpar: begin
                                if (ocnt_reg >= Full) err_next = ST_OVERFLOW;
                                else begin
                                    o_we = 1'b1;
                                    o_wdata = OP_PAREN;
                                    ocnt_next = ocnt_reg + CW'(1);
                                end
                            end
                            default: begin
                                rpar_next = (s_tdata == ChRpar);
                                priority case (s_tdata)
                                    ChAdd:   tok_next = OP_ADD;
                                    ChSub:   tok_next = OP_SUB;
                                    ChMul:   tok_next = OP_MUL;
                                    ChDiv:   tok_next = OP_DIV;
                                    default: tok_next = OP_OTHER;
                                endcase
                                // top of operator stack is read now
                                state_next = S_DECIDE;
                            end
                        endcase
                    end
                end
            end
            S_DECIDE: begin
                // o_rdata is the top operator when ocnt > 0
                if (err_reg != ST_OK) begin
                    state_next = last_reg ? S_FINTOP : S_IDLE;
                end else if (ocnt_reg != '0 && (rpar_reg ? (o_rdata != OP_PAREN)
                             : (prec(o_rdata) >= prec(tok_reg)))) begin
                    if (vcnt_reg < CW'(2)) begin
                        err_next = ST_MALFORMED;
                        state_next = last_reg ? S_FINTOP : S_IDLE;
                    end else begin
                        op_next = o_rdata;
                        ocnt_next = ocnt_reg - CW'(1);
                        v_raddr = AW'(vcnt_reg - CW'(1));
                        state_next = S_POP1;
                    end
                end else begin
                    if (rpar_reg) begin
                        if (ocnt_reg != '0) ocnt_next = ocnt_reg - CW'(1);
                    end else if (ocnt_reg >= Full) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        o_we = 1'b1;
                        o_wdata = tok_reg;
                        ocnt_next = ocnt_reg + CW'(1);
                    end
                    state_next = last_reg ? S_FINTOP : S_IDLE;
                end
            end
            S_POP1: begin
                r_next = v_rdata;
                v_raddr = AW'(vcnt_reg - CW'(2));
                state_next = S_POP2;
            end
            S_POP2: begin
                l_next = v_rdata;
                vcnt_next = vcnt_reg - CW'(2);
                cnt_next = 7'd0;
                state_next = S_WB;
                unique case (op_reg)
                    OP_ADD: acc_next = v_rdata + r_reg;
                    OP_SUB: acc_next = v_rdata - r_reg;
                    OP_MUL: begin
                        acc_next = '0;
                        state_next = S_MUL;
                    end
                    OP_DIV: begin
                        if (r_reg == '0) begin
                            err_next = ST_DIVZERO;
                            state_next = last_reg ? S_FINAL : S_IDLE;
                        end else begin
                            neg_next = v_rdata[63] ^ r_reg[63];
                            acc_next = v_rdata[63] ? -v_rdata : v_rdata;
                            r_next = r_reg[63] ? -r_reg : r_reg;
                            rem_next = '0;
                            state_next = S_DIV;
                        end
                    end
                    default: acc_next = '0;
                endcase
            end
            S_MUL: begin
                // shift-add over the bits of r, LSB first
                pres = r_reg[0] ? l_reg : '0;
                acc_next = acc_reg + pres;
                l_next = {l_reg[62:0], 1'b0};
                r_next = {1'b0, r_reg[63:1]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) state_next = S_WB;
            end
            S_DIV: begin
                // acc holds dividend shifting out, quotient shifting in
                if (!trial[64]) begin
                    rem_next = trial[63:0];
                    acc_next = {acc_reg[62:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[62:0], acc_reg[63]};
                    acc_next = {acc_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    op_next = OP_OTHER;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                v_we = 1'b1;
                v_wdata = (op_reg == OP_DIV) ? acc_reg : acc_reg;
                if (op_reg == OP_OTHER && neg_reg && cnt_reg == 7'd64)
                    v_wdata = -acc_reg;
                vcnt_next = vcnt_reg + CW'(1);
                neg_next = 1'b0;
                cnt_next = 7'd0;
                // final reduction or the pending byte continues
                state_next = (last_reg && tok_reg == OP_PAREN) ? S_FINAL : S_DECIDE;
                if (last_reg && tok_reg == OP_PAREN) state_next = S_FINAL;
                o_raddr = AW'(ocnt_reg - CW'(1));
            end
            S_FINTOP: begin
                // stack pushes of the last byte have landed; read the top again
                state_next = S_FINAL;
            end
            S_FINAL: begin
                // drain: treat as an operator reducing everything
                if (err_reg == ST_OK && ocnt_reg != '0) begin
                    if (vcnt_reg < CW'(2)) begin
                        err_next = ST_MALFORMED;
                    end else begin
                        tok_next = OP_PAREN;
                        op_next = o_rdata;
                        ocnt_next = ocnt_reg - CW'(1);
                        state_next = S_POP1;
                    end
                end else begin
                    if (err_reg == ST_OK && vcnt_reg != CW'(1)) err_next = ST_MALFORMED;
                    v_raddr = '0;
                    state_next = S_FINRD;
                end
            end
            S_FINRD: begin
                outs_next = err_reg;
                outv_next = (err_reg == ST_OK) ? v_rdata : '0;
                vcnt_next = '0;
                ocnt_next = '0;
                err_next = ST_OK;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {6'd0, outs_reg, outv_reg};

endmodule

FILE: rtl/iee_checker.sv
// Port-level checker for the evaluator, bound to the top level.
// Depends on infix_expression_evaluator_unit_defines.svh.
`include "infix_expression_evaluator_unit_defines.svh"

module iee_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    `IEE_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    `IEE_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && m_tdata[65:64] != 2'd0,
        m_tdata[63:0] == 64'd0)
    `IEE_ASSERT_NOW(a_fill_zero, aclk, aresetn, m_tvalid, m_tdata[71:66] == 6'd0)
    `IEE_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    `IEE_ASSERT_NEXT(a_last_busy, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for infix_expression_evaluator_unit: byte stream in, value/status out.
// Depends on iee_pkg and the RTL top; prediction is done by an in-bench two-stack evaluator.
module tb_top;
    import iee_pkg::*;

    localparam int unsigned Depth = 32;
    localparam int unsigned CycleLimit = 1500000;
    localparam int unsigned SettleCycles = 300;
    localparam int unsigned PhaseItems = 166;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
    } outcome_t;

    typedef struct packed {
        logic [7:0]  tok;
        logic        lst;
        logic        typed;
        logic [63:0] value;
        status_t     status;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    infix_expression_evaluator_unit uut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_wdata
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // evaluator state mirrored by the bench
    logic [63:0] operand_val [4];
    logic [63:0] value_stk [Depth];
    op_t         oper_stk [Depth];
    int          val_cnt;
    int          oper_cnt;
    status_t     err_code;

    outcome_t    pending_results[$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    int unsigned cycle_count = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    logic [7:0]  expr_bytes[$];

    // directed stimulus: typed rows carry their expected result, others use the evaluator
    stim_row_t directed_rows [25] = '{
        '{ChA, 1'b1, 1'b1, 64'd10080, ST_OK},
        '{ChB, 1'b1, 1'b1, 64'd1100, ST_OK},
        '{ChC, 1'b1, 1'b1, 64'd11180, ST_OK},
        '{ChD, 1'b1, 1'b1, 64'd12280, ST_OK},
        '{ChRpar, 1'b1, 1'b1, 64'd0, ST_MALFORMED},
        '{ChA, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChDiv, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChLpar, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChA, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChSub, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChA, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChRpar, 1'b1, 1'b1, 64'd0, ST_DIVZERO},
        '{ChSpace, 1'b1, 1'b1, 64'd0, ST_MALFORMED},
        '{ChA, 1'b0, 1'b0, 64'd0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChB, 1'b1, 1'b1, 64'd0, ST_OK},
        '{ChLpar, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChA, 1'b1, 1'b1, 64'd0, ST_MALFORMED},
        '{ChA, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChMul, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChB, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChSub, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChC, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChDiv, 1'b0, 1'b0, 64'd0, ST_OK},
        '{ChD, 1'b1, 1'b0, 64'd0, ST_OK}
    };

    function automatic int rank(op_t op);
        if (op == OP_ADD || op == OP_SUB) return 1;
        if (op == OP_MUL || op == OP_DIV) return 2;
        return 0;
    endfunction

    function automatic logic [63:0] trunc_quot(logic [63:0] l, logic [63:0] r);
        logic [63:0] ml, mr, q;
        ml = l[63] ? -l : l;
        mr = r[63] ? -r : r;
        q = ml / mr;
        return (l[63] != r[63]) ? -q : q;
    endfunction

    task automatic flag_error(status_t e);
        if (err_code == ST_OK) err_code = e;
    endtask

    task automatic push_val(logic [63:0] v);
        if (val_cnt >= Depth) begin
            flag_error(ST_OVERFLOW);
            return;
        end
        value_stk[val_cnt] = v;
        val_cnt++;
    endtask

    task automatic push_oper(op_t op);
        if (oper_cnt >= Depth) begin
            flag_error(ST_OVERFLOW);
            return;
        end
        oper_stk[oper_cnt] = op;
        oper_cnt++;
    endtask

    task automatic reduce_top();
        op_t op;
        logic [63:0] l, r, res;
        if (oper_cnt == 0) return;
        if (val_cnt < 2) begin
            flag_error(ST_MALFORMED);
            return;
        end
        oper_cnt--;
        op = oper_stk[oper_cnt];
        val_cnt--;
        r = value_stk[val_cnt];
        val_cnt--;
        l = value_stk[val_cnt];
        case (op)
            OP_ADD: res = l + r;
            OP_SUB: res = l - r;
            OP_MUL: res = l * r;
            OP_DIV: begin
                if (r == 64'd0) begin
                    flag_error(ST_DIVZERO);
                    return;
                end
                res = trunc_quot(l, r);
            end
            default: res = 64'd0;  // leftover bracket or unknown byte
        endcase
        value_stk[val_cnt] = res;
        val_cnt++;
    endtask

    task automatic apply_byte(logic [7:0] t);
        op_t op;
        case (t)
            ChSpace: ;
            ChLpar: push_oper(OP_PAREN);
            ChA: push_val(operand_val[REG_A]);
            ChB: push_val(operand_val[REG_B]);
            ChC: push_val(operand_val[REG_C]);
            ChD: push_val(operand_val[REG_D]);
            ChRpar: begin
                while (err_code == ST_OK && oper_cnt > 0 && oper_stk[oper_cnt-1] != OP_PAREN)
                    reduce_top();
                if (err_code == ST_OK && oper_cnt > 0) oper_cnt--;
            end
            default: begin
                case (t)
                    ChAdd: op = OP_ADD;
                    ChSub: op = OP_SUB;
                    ChMul: op = OP_MUL;
                    ChDiv: op = OP_DIV;
                    default: op = OP_OTHER;
                endcase
                while (err_code == ST_OK && oper_cnt > 0 && rank(oper_stk[oper_cnt-1]) >= rank(op))
                    reduce_top();
                if (err_code == ST_OK) push_oper(op);
            end
        endcase
    endtask

    // returns 1 with the expression outcome on the closing byte
    task automatic evaluate_byte(logic [7:0] t, logic lst, output bit done, output outcome_t o);
        done = 1'b0;
        o = '0;
        if (err_code == ST_OK) apply_byte(t);
        if (!lst) return;
        while (err_code == ST_OK && oper_cnt > 0) reduce_top();
        if (err_code == ST_OK && val_cnt != 1) flag_error(ST_MALFORMED);
        o.value = (err_code == ST_OK) ? value_stk[0] : 64'd0;
        o.status = err_code;
        done = 1'b1;
        val_cnt = 0;
        oper_cnt = 0;
        err_code = ST_OK;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    endtask

    task automatic send_byte(logic [7:0] t, logic lst, logic typed, outcome_t typed_o);
        bit done;
        outcome_t o;
        s_tvalid <= 1'b1;
        s_tdata <= t;
        s_tlast <= lst;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        evaluate_byte(t, lst, done, o);
        if (done) pending_results.push_back(typed ? typed_o : o);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic write_operand(reg_idx_t idx, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        operand_val[idx] = v;
    endtask

    // wait for every result, then let a trailing non-final byte finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(3))
            0: return ChA;
            1: return ChB;
            2: return ChC;
            default: return ChD;
        endcase
    endfunction

    function automatic logic [7:0] pick_oper();
        case ($urandom_range(3))
            0: return ChAdd;
            1: return ChSub;
            2: return ChMul;
            default: return ChDiv;
        endcase
    endfunction

    task automatic emit(logic [7:0] b);
        if ($urandom_range(99) < 8) expr_bytes.push_back(ChSpace);
        expr_bytes.push_back(b);
    endtask

    task automatic build_term(int lvl);
        if (lvl == 0 || $urandom_range(99) < 55) begin
            emit(pick_letter());
        end else begin
            emit(ChLpar);
            build_expr(lvl - 1);
            emit(ChRpar);
        end
    endtask

    task automatic build_expr(int lvl);
        int n;
        n = $urandom_range(3, 1);
        build_term(lvl);
        for (int i = 1; i < n; i++) begin
            emit(pick_oper());
            build_term(lvl);
        end
    endtask

    // mostly well-formed expressions; the rest noise, broken or stack-filling
    task automatic build_random_expr();
        int kind, pos;
        expr_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 75) begin
            build_expr($urandom_range(3));
        end else if (kind < 85) begin
            build_expr($urandom_range(2));
            pos = $urandom_range(expr_bytes.size() - 1);
            if ($urandom_range(1)) expr_bytes.delete(pos);
            else expr_bytes.insert(pos, 8'($urandom_range(255)));
            if (expr_bytes.size() == 0) expr_bytes.push_back(8'($urandom_range(255)));
        end else if (kind < 95) begin
            repeat ($urandom_range(6, 1)) expr_bytes.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(40, 30))
                expr_bytes.push_back($urandom_range(1) ? pick_letter() : ChLpar);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            status_seen[m_tdata[65:64]]++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[63:0] !== want.value)
                    report_mismatch("value", m_tdata[63:0], want.value);
                if (m_tdata[65:64] !== want.status)
                    report_mismatch("status", 64'(m_tdata[65:64]), 64'(want.status));
            end
        end
    end

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int gap_mode [4][2];
        logic [63:0] cfg_set [8][4];
        int phase_bytes;
        gap_mode = '{'{0, 0}, '{79, 0}, '{0, 79}, '{35, 35}};
        cfg_set = '{
            '{ResetOperandA, ResetOperandB, ResetOperandC, ResetOperandD},
            '{64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd0, '1},
            '{64'h8000_0000_0000_0000, '1, 64'd1, 64'd0},
            '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}},
            '{64'($signed(6'($urandom))), 64'($signed(6'($urandom))),
              64'($signed(6'($urandom))), 64'($signed(6'($urandom)))},
            '{{$urandom, $urandom}, 64'($urandom), -64'($urandom), 64'($urandom_range(3))},
            '{'1, 64'd1, 64'd2, -64'd2},
            '{{$urandom, $urandom}, {$urandom, $urandom}, 64'd7, -64'd7}
        };
        operand_val = '{ResetOperandA, ResetOperandB, ResetOperandC, ResetOperandD};
        val_cnt = 0;
        oper_cnt = 0;
        err_code = ST_OK;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].tok, directed_rows[i].lst, directed_rows[i].typed,
                      '{directed_rows[i].value, directed_rows[i].status});
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p != 0) begin
                for (int r = 0; r < 4; r++) write_operand(reg_idx_t'(r), cfg_set[p][r]);
                cfg_we <= 1'b0;
                @(posedge aclk);
            end
            send_gap_pct = gap_mode[p % 4][0];
            recv_stall_pct = gap_mode[p % 4][1];
            phase_bytes = 0;
            while (phase_bytes < PhaseItems) begin
                build_random_expr();
                foreach (expr_bytes[k])
                    send_byte(expr_bytes[k], k == expr_bytes.size() - 1, 1'b0, '0);
                phase_bytes += expr_bytes.size();
            end
            drain();
        end

        $display("Sent %0d bytes, checked %0d results over 8 operand settings and 4 idle modes",
                 bytes_sent, results_seen);
        $display("Status mix: ok %0d, malformed %0d, divide by zero %0d, overflow %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
